[rtl/core/cacs_pkg.sv]
`default_nettype none
package cacs_pkg;

  parameter int unsigned MaxSectionBytesDef = 4096;
  parameter int unsigned MaxMessageBytesDef = 256;

  localparam logic [31:0] CrcPoly = 32'h04c1_1db7;
  localparam logic [31:0] CrcInit = 32'hffff_ffff;

  localparam logic [7:0] TableEcm       = 8'h82;
  localparam logic [7:0] TableCommonEmm = 8'h84;
  localparam logic [7:0] TableIndivEmm  = 8'h85;

  localparam logic [7:0] MarkerMaskLen = 8'hb0;
  localparam logic [7:0] MarkerMaskVer = 8'hc0;

  localparam int unsigned MinSectionBytes = 12;
  localparam int unsigned MinEcmBody      = 30;
  localparam int unsigned MinCommonMsg    = 17;
  localparam int unsigned MinIndivMsg     = 25;
  localparam int unsigned HeaderBytes     = 8;
  localparam int unsigned CommonHdrBytes  = 7;
  localparam int unsigned IndivHdrBytes   = 8;

  typedef enum logic [1:0] {
    VERDICT_OK,
    VERDICT_BAD,
    VERDICT_UNSUPPORTED
  } verdict_e;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_ECM,
    KIND_COMMON_EMM,
    KIND_INDIV_EMM
  } kind_e;

  function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] data);
    logic [31:0] crc;
    crc = crc_in ^ {data, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      crc = {crc[30:0], 1'b0} ^ (crc[31] ? CrcPoly : 32'h0);
    end
    return crc;
  endfunction

  function automatic kind_e kind_of(logic [7:0] table_id);
    kind_e k;
    case (table_id)
      TableEcm:       k = KIND_ECM;
      TableCommonEmm: k = KIND_COMMON_EMM;
      TableIndivEmm:  k = KIND_INDIV_EMM;
      default:        k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ca_section_checker_splitter.sv]
// Conditional-access section checker and splitter.
// Input channel (in_valid_i/in_ready_o) carries one section byte per request,
// starting at the table id, with last_byte_i set on the final byte. Output
// channel (out_valid_o/out_ready_i) returns exactly one result per byte: the
// byte echoed, body and message-start marks, the EMM message index, the
// section kind and, on the last byte, a verdict (ok, bad, unsupported).
// out_valid_o rises the cycle after acceptance. One byte is taken every cycle
// unless stalled: the CRC-32 byte step and header/message parsing sit in a
// single combinational pass between the parser state and the result register.
// A new byte is taken whenever the result register is empty or being drained
// in the same cycle; while the receiver stalls, the result is held and
// in_ready_o stays low.
// Reset clears all parser state, presets the CRC to all ones and empties the
// result register. After the last byte of a section the parser returns to its
// reset state by itself, so sections may follow back to back.
// Downstream should drop a section whose verdict is not ok.
`default_nettype none
module ca_section_checker_splitter #(
  parameter int unsigned MAX_SECTION_BYTES = cacs_pkg::MaxSectionBytesDef,
  parameter int unsigned MAX_MESSAGE_BYTES = cacs_pkg::MaxMessageBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      echo_byte_o,
  output logic            in_body_o,
  output logic            message_start_o,
  output logic [7:0]      message_number_o,
  output logic [1:0]      section_kind_o,
  output logic            section_done_o,
  output logic [1:0]      verdict_o
);

  localparam int unsigned CntW = $clog2(MAX_SECTION_BYTES + 2);
  localparam int unsigned MszW = $clog2(MAX_MESSAGE_BYTES + 2);
  localparam int unsigned OffW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [16:0] MszSat = 17'(MAX_MESSAGE_BYTES + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [11:0]     dlen_q, dlen_d;
  logic [31:0]     crc_q, crc_d;
  logic [7:0]      table_q, table_d;
  logic            hfault_q, hfault_d;
  logic            curnext_q, curnext_d;
  logic            extnz_q, extnz_d;
  logic [OffW-1:0] off_q, off_d;
  logic [MszW-1:0] msz_q, msz_d;
  logic [7:0]      hi_q, hi_d;
  logic [7:0]      mcnt_q, mcnt_d;
  logic            bfault_q, bfault_d;

  logic            out_valid_q;
  logic [7:0]      echo_q;
  logic            body_q, start_q, done_q;
  logic [7:0]      number_q;
  cacs_pkg::kind_e    kind_q, kind_d;
  cacs_pkg::verdict_e verdict_q, verdict_d;

  logic       accept;
  logic       body_d, start_d;
  logic [7:0] number_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  function automatic logic [MszW-1:0] sat_size(logic [16:0] raw);
    return (raw > MszSat) ? MszSat[MszW-1:0] : raw[MszW-1:0];
  endfunction

  always_comb begin
    logic            indiv;
    logic [OffW-1:0] hdr;
    logic [MszW-1:0] min_sz;
    logic [31:0]     size;

    cnt_d     = cnt_q;
    dlen_d    = dlen_q;
    table_d   = table_q;
    hfault_d  = hfault_q;
    curnext_d = curnext_q;
    extnz_d   = extnz_q;
    off_d     = off_q;
    msz_d     = msz_q;
    hi_d      = hi_q;
    mcnt_d    = mcnt_q;
    bfault_d  = bfault_q;
    body_d    = 1'b0;
    start_d   = 1'b0;
    number_d  = 8'h00;
    verdict_d = cacs_pkg::VERDICT_OK;

    indiv  = (table_q == cacs_pkg::TableIndivEmm);
    hdr    = indiv ? OffW'(cacs_pkg::IndivHdrBytes) : OffW'(cacs_pkg::CommonHdrBytes);
    min_sz = indiv ? MszW'(cacs_pkg::MinIndivMsg) : MszW'(cacs_pkg::MinCommonMsg);

    crc_d = cacs_pkg::crc_byte(crc_q, data_byte_i);

    if (cnt_q == CntW'(0)) begin
      table_d = data_byte_i;
    end else if (cnt_q == CntW'(1)) begin
      if ((data_byte_i & cacs_pkg::MarkerMaskLen) != cacs_pkg::MarkerMaskLen) hfault_d = 1'b1;
      dlen_d = {data_byte_i[3:0], 8'h00};
    end else if (cnt_q == CntW'(2)) begin
      dlen_d = {dlen_q[11:8], data_byte_i};
    end else if (cnt_q == CntW'(3) || cnt_q == CntW'(4)) begin
      if (data_byte_i != 8'h00) extnz_d = 1'b1;
    end else if (cnt_q == CntW'(5)) begin
      if ((data_byte_i & cacs_pkg::MarkerMaskVer) != cacs_pkg::MarkerMaskVer) hfault_d = 1'b1;
      curnext_d = data_byte_i[0];
    end else if (cnt_q == CntW'(6)) begin
      hi_d = data_byte_i;
    end else if (cnt_q == CntW'(7)) begin
      if (hi_q > data_byte_i) hfault_d = 1'b1;
    end else if ((32'(cnt_q) + 32'd1) < 32'(dlen_q)) begin
      body_d = 1'b1;
      if (table_q == cacs_pkg::TableEcm) begin
        start_d = (cnt_q == CntW'(cacs_pkg::HeaderBytes));
      end else if ((table_q == cacs_pkg::TableCommonEmm || indiv) && !bfault_q) begin
        start_d  = (off_q == OffW'(0));
        number_d = mcnt_q;
        if (off_q == OffW'(6)) begin
          if (indiv) hi_d = data_byte_i;
          else msz_d = sat_size(17'(cacs_pkg::CommonHdrBytes) + {9'h000, data_byte_i});
        end else if (off_q == OffW'(7) && indiv) begin
          msz_d = sat_size(17'(cacs_pkg::IndivHdrBytes) + {1'b0, hi_q, data_byte_i});
        end
        if (off_q == hdr - OffW'(1) &&
            (msz_d < min_sz || 32'(msz_d) > 32'(MAX_MESSAGE_BYTES))) begin
          bfault_d = 1'b1;
        end
        off_d = off_q + OffW'(1);
        // close the message once header and payload are both consumed
        if (!bfault_d && off_d >= hdr && 32'(off_d) >= 32'(msz_d)) begin
          off_d  = '0;
          msz_d  = '0;
          mcnt_d = mcnt_q + 8'd1;
        end
      end
    end

    if (32'(cnt_q) <= 32'(MAX_SECTION_BYTES)) cnt_d = cnt_q + CntW'(1);

    kind_d = cacs_pkg::kind_of(table_d);
    size   = 32'(cnt_d);

    if (last_byte_i) begin
      if (size < 32'(cacs_pkg::MinSectionBytes) || size > 32'(MAX_SECTION_BYTES) ||
          (32'(dlen_d) + 32'd3) != size || hfault_d || crc_d != 32'h0) begin
        verdict_d = cacs_pkg::VERDICT_BAD;
      end else if (!curnext_d) begin
        verdict_d = cacs_pkg::VERDICT_UNSUPPORTED;
      end else if (table_d == cacs_pkg::TableEcm) begin
        if (size < 32'(cacs_pkg::MinSectionBytes + cacs_pkg::MinEcmBody) ||
            size > 32'(cacs_pkg::MinSectionBytes + MAX_MESSAGE_BYTES)) begin
          verdict_d = cacs_pkg::VERDICT_BAD;
        end
      end else if (table_d == cacs_pkg::TableCommonEmm ||
                   table_d == cacs_pkg::TableIndivEmm) begin
        if (table_d == cacs_pkg::TableIndivEmm && extnz_d) begin
          verdict_d = cacs_pkg::VERDICT_UNSUPPORTED;
        end else if (size == 32'(cacs_pkg::MinSectionBytes) || bfault_d ||
                     off_d != OffW'(0)) begin
          verdict_d = cacs_pkg::VERDICT_BAD;
        end
      end else begin
        verdict_d = cacs_pkg::VERDICT_UNSUPPORTED;
      end
    end
  end

  // parser state: advance on each request, drop back to reset after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      dlen_q    <= '0;
      crc_q     <= cacs_pkg::CrcInit;
      table_q   <= '0;
      hfault_q  <= 1'b0;
      curnext_q <= 1'b0;
      extnz_q   <= 1'b0;
      off_q     <= '0;
      msz_q     <= '0;
      hi_q      <= '0;
      mcnt_q    <= '0;
      bfault_q  <= 1'b0;
    end else if (accept) begin
      if (last_byte_i) begin
        cnt_q     <= '0;
        dlen_q    <= '0;
        crc_q     <= cacs_pkg::CrcInit;
        table_q   <= '0;
        hfault_q  <= 1'b0;
        curnext_q <= 1'b0;
        extnz_q   <= 1'b0;
        off_q     <= '0;
        msz_q     <= '0;
        hi_q      <= '0;
        mcnt_q    <= '0;
        bfault_q  <= 1'b0;
      end else begin
        cnt_q     <= cnt_d;
        dlen_q    <= dlen_d;
        crc_q     <= crc_d;
        table_q   <= table_d;
        hfault_q  <= hfault_d;
        curnext_q <= curnext_d;
        extnz_q   <= extnz_d;
        off_q     <= off_d;
        msz_q     <= msz_d;
        hi_q      <= hi_d;
        mcnt_q    <= mcnt_d;
        bfault_q  <= bfault_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      echo_q    <= data_byte_i;
      body_q    <= body_d;
      start_q   <= start_d;
      number_q  <= number_d;
      kind_q    <= kind_d;
      done_q    <= last_byte_i;
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign echo_byte_o      = echo_q;
  assign in_body_o        = body_q;
  assign message_start_o  = start_q;
  assign message_number_o = number_q;
  assign section_kind_o   = kind_q;
  assign section_done_o   = done_q;
  assign verdict_o        = verdict_q;

`ifndef SYNTHESIS
  a_verdict_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !section_done_o |-> verdict_o == cacs_pkg::VERDICT_OK)
    else $error("verdict given on a byte that is not the last");

  a_start_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_start_o |-> in_body_o)
    else $error("message start outside the body");

  a_number_emm_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_number_o != 8'h00 |->
      in_body_o && (section_kind_o == cacs_pkg::KIND_COMMON_EMM ||
                    section_kind_o == cacs_pkg::KIND_INDIV_EMM))
    else $error("message number set outside an EMM body");

  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_byte_i |=> cnt_q == '0 && crc_q == cacs_pkg::CrcInit && !bfault_q)
    else $error("parser not back to reset after the last byte");
`endif

endmodule
`default_nettype wire
